[hw/rtl/qsd_pkg.sv]
// Package for the query string pair decoder: codes, state and result types, hex decode.
`timescale 1ns / 1ps

package qsd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam logic [1:0] KindKey    = 2'd0;
  localparam logic [1:0] KindValue  = 2'd1;
  localparam logic [1:0] KindMarker = 2'd2;

  localparam logic [1:0] StKept    = 2'd0;
  localparam logic [1:0] StDropped = 2'd1;
  localparam logic [1:0] StBad     = 2'd2;

  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscFirst = 2'd1;
  localparam logic [1:0] EscSecond = 2'd2;

  localparam logic ModeByte = 1'b0;
  localparam logic ModeEnd  = 1'b1;

  typedef struct packed {
    logic       in_value;
    logic       key_nonempty;
    logic [1:0] escape_phase;
    logic [3:0] high_nibble;
    logic       pair_bad;
    logic       aborted;
  } state_t;

  typedef struct packed {
    logic       end_of_string;
    logic [1:0] pair_status;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
  } result_t;

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

[hw/rtl/qsd_step.sv]
// Per-byte decode step: next parser state and the optional result item.
`timescale 1ns / 1ps

module qsd_step (
  input  qsd_pkg::state_t  state_i,
  input  logic             mode_i,
  input  logic [7:0]       in_byte_i,
  output qsd_pkg::state_t  state_o,
  output logic             res_valid_o,
  output qsd_pkg::result_t res_o
);

  logic [4:0] hex;
  logic [1:0] kind;
  logic [1:0] status;

  assign hex  = qsd_pkg::hex_val(in_byte_i);
  assign kind = state_i.in_value ? qsd_pkg::KindValue : qsd_pkg::KindKey;

  always_comb begin
    priority if (!state_i.in_value || !state_i.key_nonempty) begin
      status = qsd_pkg::StDropped;
    end else if (state_i.pair_bad || state_i.escape_phase != qsd_pkg::EscNone) begin
      status = qsd_pkg::StBad;
    end else begin
      status = qsd_pkg::StKept;
    end
  end

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    priority if (state_i.aborted) begin
      if (mode_i == qsd_pkg::ModeEnd) begin
        state_o = '0;
      end
    end else if (mode_i == qsd_pkg::ModeEnd || in_byte_i == qsd_pkg::ChAmp) begin
      res_valid_o         = 1'b1;
      res_o.out_kind      = qsd_pkg::KindMarker;
      res_o.pair_status   = status;
      res_o.end_of_string = mode_i;
      state_o             = '0;
      state_o.aborted     = (mode_i == qsd_pkg::ModeByte) && (status == qsd_pkg::StBad);
    end else if (in_byte_i == qsd_pkg::ChEq && !state_i.in_value) begin
      if (state_i.escape_phase != qsd_pkg::EscNone) begin
        state_o.pair_bad = 1'b1;
      end
      state_o.escape_phase = qsd_pkg::EscNone;
      state_o.in_value     = 1'b1;
    end else begin
      if (!state_i.in_value) begin
        state_o.key_nonempty = 1'b1;
      end
      priority if (state_i.escape_phase != qsd_pkg::EscNone) begin
        priority if (hex[4]) begin
          state_o.pair_bad     = 1'b1;
          state_o.escape_phase = qsd_pkg::EscNone;
        end else if (state_i.escape_phase == qsd_pkg::EscFirst) begin
          state_o.high_nibble  = hex[3:0];
          state_o.escape_phase = qsd_pkg::EscSecond;
        end else begin
          state_o.escape_phase = qsd_pkg::EscNone;
          res_valid_o          = !state_i.pair_bad;
          res_o.out_kind       = kind;
          res_o.out_byte       = {state_i.high_nibble, hex[3:0]};
        end
      end else if (in_byte_i == qsd_pkg::ChPercent) begin
        state_o.escape_phase = qsd_pkg::EscFirst;
      end else begin
        res_valid_o    = !state_i.pair_bad;
        res_o.out_kind = kind;
        res_o.out_byte = (in_byte_i == qsd_pkg::ChPlus) ? qsd_pkg::ChSpace : in_byte_i;
      end
    end
  end

endmodule

[hw/rtl/query_string_pair_decoder_core.sv]
// Query string pair decoder: percent-decodes key/value bytes and marks pair ends.
// Results are registered: each goes to the result register, or to the skid register while the master side stalls.
// Throughput: one input byte per cycle while the skid register is empty; the parser state update is a single step.
// A two-entry output buffer (result register plus skid register) keeps the input
// side open for one more transfer while the master side stalls.
// Reset (rst_ni low, asynchronous): parser state cleared, output buffer empty.
`timescale 1ns / 1ps

module query_string_pair_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  logic        s_axis_tuser_i,  // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] out_byte, [9:8] pair_status, zero above
  output logic [1:0]  m_axis_tuser_o,  // [1:0] out_kind
  output logic        m_axis_tlast_o   // end_of_string
);

  qsd_pkg::state_t  state_q, state_d;
  qsd_pkg::result_t res;
  qsd_pkg::result_t out_q, skid_q;
  logic             res_valid;
  logic             out_valid_q, skid_valid_q;
  logic             accept, push, pop;

  qsd_step u_step (
    .state_i     (state_q),
    .mode_i      (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = accept && res_valid;
  assign pop             = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_q.pair_status, out_q.out_byte};
  assign m_axis_tuser_o  = out_q.out_kind;
  assign m_axis_tlast_o  = out_q.end_of_string;

endmodule
